### sv/owm_pkg.sv
package owm_pkg;

    // sine table resolution in fraction bits
    localparam int SINE_BITS   = 16;
    localparam int SINE_W      = SINE_BITS + 1;
    localparam int SIN_ENTRIES = 91;
    localparam int NUM_LANES   = 4;

    // pi in q30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [8:0] angle_t;

    localparam angle_t FULL_TURN     = 9'd360;
    localparam angle_t HALF_TURN     = 9'd180;
    localparam angle_t THREE_QUARTER = 9'd270;
    localparam angle_t QUARTER_TURN  = 9'd90;

    localparam angle_t LANE_OFFSET [NUM_LANES] = '{9'd45, 9'd135, 9'd225, 9'd315};

    localparam logic [6:0] MAG_LIMIT = 7'd100;
    localparam logic [2:0] DIV_TOP   = 3'd6;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_ONE  = 8'h31;
    localparam logic [7:0] ASCII_F    = 8'h46;
    localparam logic [7:0] ASCII_R    = 8'h52;
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_LF   = 8'h0A;

    typedef logic [SINE_W-1:0] sin_lut_t [SIN_ENTRIES];

    // lane step strobes from the sequencer
    typedef struct packed {
        logic       fold;
        logic       mul;
        logic       max;
        logic       div;
        logic       div_first;
        logic [2:0] div_bit;
        logic       fmt;
    } owm_ctrl_t;

    // one formatted channel: direction and three decimal digits
    typedef struct packed {
        logic       rev;
        logic       hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } owm_chan_t;

    // quarter wave sine magnitude, q30 taylor series rounded to SINE_BITS
    function automatic sin_lut_t build_sin_lut();
        sin_lut_t          lut;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint            sum;
        longint unsigned   s;
        for (int d = 0; d < SIN_ENTRIES; d++) begin
            x   = (longint'(d) * PI_Q30) / 180;
            x2  = (x * x) >> 30;
            t   = x;
            sum = longint'(x);
            t   = ((t * x2) >> 30) / 6;
            sum = sum - longint'(t);
            t   = ((t * x2) >> 30) / 20;
            sum = sum + longint'(t);
            t   = ((t * x2) >> 30) / 42;
            sum = sum - longint'(t);
            t   = ((t * x2) >> 30) / 72;
            sum = sum + longint'(t);
            t   = ((t * x2) >> 30) / 110;
            sum = sum - longint'(t);
            t   = ((t * x2) >> 30) / 156;
            sum = sum + longint'(t);
            t   = ((t * x2) >> 30) / 210;
            sum = sum - longint'(t);
            t   = ((t * x2) >> 30) / 272;
            sum = sum + longint'(t);
            if (sum < 0) begin
                sum = 0;
            end
            s = longint'(sum);
            s = (((s << 1) >> (30 - SINE_BITS)) + 1) >> 1;
            lut[d] = s[SINE_W-1:0];
        end
        return lut;
    endfunction

    localparam sin_lut_t SIN_LUT = build_sin_lut();

endpackage

### sv/owm_lane.sv
module owm_lane import owm_pkg::*; (
    input  logic              aclk,
    input  owm_ctrl_t         ctrl,
    input  logic [1:0]        lane_id,
    input  logic              command,
    input  angle_t            heading,
    input  logic [6:0]        speed,
    input  logic signed [7:0] wheel,
    input  logic [6:0]        mx,
    output logic [6:0]        mag,
    output owm_chan_t         result
);

    logic [9:0]            ang_sum;
    angle_t                ang;
    logic [6:0]            d_next;
    logic                  neg_next;
    logic [6:0]            d_reg;
    logic                  neg_reg;
    logic [SINE_W+6:0]     prod;
    logic [6:0]            mag_reg;
    logic [13:0]           num_reg;
    logic [6:0]            num_lo;
    logic [6:0]            rem_cur;
    logic [7:0]            trial;
    logic                  qbit;
    logic [6:0]            rem_next;
    logic [6:0]            rem_reg;
    logic [6:0]            quo_reg;
    logic [6:0]            quo_fix;
    logic                  in_range;
    logic                  rev;
    logic [6:0]            m;
    logic signed [7:0]     wheel_neg;
    logic [14:0]           t10;
    logic                  hund;
    logic [3:0]            tens;
    logic [6:0]            tens10;
    logic [6:0]            ones_full;
    owm_chan_t             res_reg;

    // wheel angle, then fold into the first quadrant
    always_comb begin
        ang_sum = {1'b0, heading} + {1'b0, LANE_OFFSET[lane_id]};
        if (ang_sum >= {1'b0, FULL_TURN}) begin
            ang = 9'(ang_sum - {1'b0, FULL_TURN});
        end else begin
            ang = ang_sum[8:0];
        end
        if (ang <= QUARTER_TURN) begin
            d_next   = ang[6:0];
            neg_next = 1'b0;
        end else if (ang <= HALF_TURN) begin
            d_next   = 7'(HALF_TURN - ang);
            neg_next = 1'b0;
        end else if (ang <= THREE_QUARTER) begin
            d_next   = 7'(ang - HALF_TURN);
            neg_next = 1'b1;
        end else begin
            d_next   = 7'(FULL_TURN - ang);
            neg_next = 1'b1;
        end
    end

    assign prod = SIN_LUT[d_reg] * {{SINE_W{1'b0}}, speed};

    // restoring division, one quotient bit a step
    assign num_lo   = num_reg[6:0];
    assign rem_cur  = ctrl.div_first ? num_reg[13:7] : rem_reg;
    assign trial    = {rem_cur, num_lo[ctrl.div_bit]};
    assign qbit     = (trial >= {1'b0, mx});
    assign rem_next = qbit ? 7'(trial - {1'b0, mx}) : trial[6:0];

    // channel value, range check and decimal digits
    always_comb begin
        quo_fix   = (mx == 7'd0) ? 7'd0 : quo_reg;
        wheel_neg = -wheel;
        if (command) begin
            in_range = (wheel >= -8'sd100) && (wheel <= 8'sd100);
            rev      = in_range && (wheel < 8'sd0);
            if (!in_range) begin
                m = 7'd0;
            end else if (wheel < 8'sd0) begin
                m = wheel_neg[6:0];
            end else begin
                m = wheel[6:0];
            end
        end else begin
            in_range = (quo_fix <= MAG_LIMIT);
            rev      = in_range && neg_reg && (quo_fix != 7'd0);
            m        = in_range ? quo_fix : 7'd0;
        end
        hund      = (m == MAG_LIMIT);
        t10       = {8'd0, m} * 15'd205;
        tens      = hund ? 4'd0 : t10[14:11];
        tens10    = 7'({3'd0, tens} * 7'd10);
        ones_full = hund ? 7'd0 : 7'(m - tens10);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fold) begin
            d_reg   <= d_next;
            neg_reg <= neg_next;
        end
        if (ctrl.mul) begin
            mag_reg <= prod[SINE_BITS+6:SINE_BITS];
        end
        if (ctrl.max) begin
            num_reg <= 14'(mag_reg * speed);
        end
        if (ctrl.div) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[5:0], qbit};
        end
        if (ctrl.fmt) begin
            res_reg.rev  <= rev;
            res_reg.hund <= hund;
            res_reg.tens <= tens;
            res_reg.ones <= ones_full[3:0];
        end
    end

    assign mag    = mag_reg;
    assign result = res_reg;

endmodule

### sv/owm_max.sv
module owm_max import owm_pkg::*; (
    input  logic       aclk,
    input  owm_ctrl_t  ctrl,
    input  logic [6:0] mags [NUM_LANES],
    output logic [6:0] mx
);

    logic [6:0] m01;
    logic [6:0] m23;
    logic [6:0] mx_reg;

    assign m01 = (mags[0] >= mags[1]) ? mags[0] : mags[1];
    assign m23 = (mags[2] >= mags[3]) ? mags[2] : mags[3];

    always_ff @(posedge aclk) begin
        if (ctrl.max) begin
            mx_reg <= (m01 >= m23) ? m01 : m23;
        end
    end

    assign mx = mx_reg;

endmodule

### sv/owm_frame.sv
module owm_frame import owm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_valid,
    output logic       load_ready,
    input  owm_chan_t  chans [NUM_LANES],
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_frame_last
);

    localparam logic [2:0] FLD_ID   = 3'd0;
    localparam logic [2:0] FLD_DIR  = 3'd1;
    localparam logic [2:0] FLD_HUND = 3'd2;
    localparam logic [2:0] FLD_TENS = 3'd3;
    localparam logic [2:0] FLD_ONES = 3'd4;
    localparam logic [2:0] FLD_CR   = 3'd5;
    localparam logic [2:0] FLD_LF   = 3'd6;

    logic       active_reg;
    logic [1:0] chan_reg;
    logic [2:0] field_reg;
    owm_chan_t  ch_reg [NUM_LANES];
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       valid_reg;
    logic       adv;
    owm_chan_t  cur;
    logic [7:0] cur_byte;

    assign adv        = !valid_reg || m_ready;
    // next frame loads as the line feed goes out
    assign load_ready = !active_reg || (adv && (field_reg == FLD_LF));
    assign cur        = ch_reg[chan_reg];

    always_comb begin
        case (field_reg)
            FLD_ID:   cur_byte = ASCII_ONE + {6'd0, chan_reg};
            FLD_DIR:  cur_byte = cur.rev ? ASCII_R : ASCII_F;
            FLD_HUND: cur_byte = ASCII_ZERO + {7'd0, cur.hund};
            FLD_TENS: cur_byte = ASCII_ZERO + {4'd0, cur.tens};
            FLD_ONES: cur_byte = ASCII_ZERO + {4'd0, cur.ones};
            FLD_CR:   cur_byte = ASCII_CR;
            FLD_LF:   cur_byte = ASCII_LF;
            default:  cur_byte = ASCII_CR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            chan_reg   <= 2'd0;
            field_reg  <= FLD_ID;
        end else begin
            if (adv) begin
                valid_reg <= active_reg;
            end
            if (load_valid && load_ready) begin
                active_reg <= 1'b1;
            end else if (adv && active_reg && (field_reg == FLD_LF)) begin
                active_reg <= 1'b0;
            end
            if (adv && active_reg) begin
                if (field_reg == FLD_LF) begin
                    chan_reg  <= 2'd0;
                    field_reg <= FLD_ID;
                end else if (field_reg == FLD_ONES && chan_reg != 2'(NUM_LANES - 1)) begin
                    chan_reg  <= chan_reg + 2'd1;
                    field_reg <= FLD_ID;
                end else begin
                    field_reg <= field_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && active_reg) begin
            byte_reg <= cur_byte;
            last_reg <= (field_reg == FLD_LF);
        end
        if (load_valid && load_ready) begin
            ch_reg <= chans;
        end
    end

    assign m_valid      = valid_reg;
    assign m_frame_byte = byte_reg;
    assign m_frame_last = last_reg;

endmodule

### sv/omni_wheel_mix_ascii_frame.sv
// the mixer steps through fold, sine multiply, max, 7 divide steps and format for each
// command, then hands off to the byte serializer, which sends a 22-beat frame at one beat
// a cycle while m_ready is high; the mixer overlaps the previous frame, so the next command
// is taken while bytes still go out; reset: synchronous, active low aresetn clears sequencer
// and serializer control; no tables or memories need clearing
module omni_wheel_mix_ascii_frame import owm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [8:0]        s_heading_deg,
    input  logic [6:0]        s_drive_speed,
    input  logic signed [7:0] s_wheel_one,
    input  logic signed [7:0] s_wheel_two,
    input  logic signed [7:0] s_wheel_three,
    input  logic signed [7:0] s_wheel_four,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_frame_byte,
    output logic              m_frame_last
);

    // mixer sequence, one command in flight
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_MUL,
        ST_MAX,
        ST_DIV,
        ST_FMT,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [2:0]        cnt_reg;

    // captured command
    logic              cmd_reg;
    angle_t            head_reg;
    logic [6:0]        speed_reg;
    logic signed [7:0] wheel_reg [NUM_LANES];

    logic              accept;
    logic              load_valid;
    logic              load_ready;
    angle_t            head_mod;
    owm_ctrl_t         ctrl;
    logic [6:0]        mags [NUM_LANES];
    logic [6:0]        mx;
    owm_chan_t         lane_res [NUM_LANES];
    owm_chan_t         frame_chan [NUM_LANES];

    // a new command may enter while the finished one is handed to the serializer
    assign s_ready    = (state_reg == ST_IDLE) || ((state_reg == ST_HOLD) && load_ready);
    assign accept     = s_valid && s_ready;
    assign load_valid = (state_reg == ST_HOLD);

    // heading wraps once, the port tops out below two turns
    assign head_mod = (s_heading_deg >= FULL_TURN) ? 9'(s_heading_deg - FULL_TURN)
                                                   : s_heading_deg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= DIV_TOP;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_MAX;
                end
                ST_MAX: begin
                    state_reg <= ST_DIV;
                    cnt_reg   <= DIV_TOP;
                end
                ST_DIV: begin
                    if (cnt_reg == 3'd0) begin
                        state_reg <= ST_FMT;
                    end else begin
                        cnt_reg <= cnt_reg - 3'd1;
                    end
                end
                ST_FMT: begin
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (load_ready) begin
                        state_reg <= accept ? ST_FOLD : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_command;
            head_reg     <= head_mod;
            speed_reg    <= s_drive_speed;
            wheel_reg[0] <= s_wheel_one;
            wheel_reg[1] <= s_wheel_two;
            wheel_reg[2] <= s_wheel_three;
            wheel_reg[3] <= s_wheel_four;
        end
    end

    // step strobes shared by all lanes
    always_comb begin
        ctrl.fold      = (state_reg == ST_FOLD);
        ctrl.mul       = (state_reg == ST_MUL);
        ctrl.max       = (state_reg == ST_MAX);
        ctrl.div       = (state_reg == ST_DIV);
        ctrl.div_first = (state_reg == ST_DIV) && (cnt_reg == DIV_TOP);
        ctrl.div_bit   = cnt_reg;
        ctrl.fmt       = (state_reg == ST_FMT);
    end

    // one lane per wheel
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        owm_lane u_lane (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .lane_id (2'(i)),
            .command (cmd_reg),
            .heading (head_reg),
            .speed   (speed_reg),
            .wheel   (wheel_reg[i]),
            .mx      (mx),
            .mag     (mags[i]),
            .result  (lane_res[i])
        );
    end

    // largest wheel magnitude, the rescale divisor
    owm_max u_max (
        .aclk (aclk),
        .ctrl (ctrl),
        .mags (mags),
        .mx   (mx)
    );

    // mix mode sends wheels 1, 2, 4, 3; direct mode keeps port order
    assign frame_chan[0] = lane_res[0];
    assign frame_chan[1] = lane_res[1];
    assign frame_chan[2] = cmd_reg ? lane_res[2] : lane_res[3];
    assign frame_chan[3] = cmd_reg ? lane_res[3] : lane_res[2];

    owm_frame u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_valid   (load_valid),
        .load_ready   (load_ready),
        .chans        (frame_chan),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_last (m_frame_last)
    );

`ifndef NO_ASSERTIONS
    // a taken command keeps the mixer busy for the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command accepted while mixer busy");

    // divisor bounds every lane magnitude during the divide
    a_max_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> (mx >= mags[0]) && (mx >= mags[1]) &&
                                (mx >= mags[2]) && (mx >= mags[3]))
        else $error("rescale divisor below a wheel magnitude");

    // handed-off digits are decimal
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load_valid && load_ready |->
            (frame_chan[0].tens <= 4'd9) && (frame_chan[0].ones <= 4'd9) &&
            (frame_chan[1].tens <= 4'd9) && (frame_chan[1].ones <= 4'd9) &&
            (frame_chan[2].tens <= 4'd9) && (frame_chan[2].ones <= 4'd9) &&
            (frame_chan[3].tens <= 4'd9) && (frame_chan[3].ones <= 4'd9))
        else $error("channel digit out of decimal range");

    // the closing beat of a frame is the line feed
    a_last_is_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_frame_byte == ASCII_LF)
        else $error("frame end not on line feed");
`endif

endmodule
